/* src/ale_pkg.sv */
// Package with shared opcodes, status codes and widths for the array list engine.
`timescale 1ns / 1ps
`default_nettype none
package ale_pkg;
  localparam int ValW = 32;
  localparam int ResW = 38;
  localparam int IdxW = 6;
  localparam int CntW = 7;

  localparam logic [3:0] OP_APPEND  = 4'd0;
  localparam logic [3:0] OP_INSERT  = 4'd1;
  localparam logic [3:0] OP_DELETE  = 4'd2;
  localparam logic [3:0] OP_SORTINS = 4'd3;
  localparam logic [3:0] OP_FIND    = 4'd4;
  localparam logic [3:0] OP_BSEARCH = 4'd5;
  localparam logic [3:0] OP_SORT    = 4'd6;
  localparam logic [3:0] OP_MAX     = 4'd7;
  localparam logic [3:0] OP_SUM     = 4'd8;
  localparam logic [3:0] OP_REVERSE = 4'd9;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_NOTFND = 2'd3;

  typedef struct packed {
    logic [ResW-1:0] value;
    logic [IdxW-1:0] index;
    logic [1:0]      status;
    logic [CntW-1:0] count;
  } result_t;
endpackage
`default_nettype wire

/* src/ale_mem.sv */
// Entry storage: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ale_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/array_list_engine_top.sv */
// Top level of the array list engine: command decode, sequencer and entry memory.
//
// Usage: drive in_func, in_position and in_operand_value and pulse start while
// busy is low. The block raises busy, walks the list in its entry memory and
// then presents one result word on the out_ ports for exactly one cycle,
// marked by out_valid. The receiver cannot stall, so the result is simply
// dropped onto the ports.
//
// Walks: a command that needs no memory walk goes straight to the done state.
// Each entry walked costs an address step, then a registered data step, in
// insert, delete, find, max and sum; a find hit past the front adds a swap
// with the front entry, reverse swaps pairs and binary search halves the
// range per probe. Sort is a bubble sort. The single read port of the entry
// memory paces all these walks. One command is in flight at a time; the next
// start is taken in the cycle that carries the result.
//
// Configuration: cfg_valid/cfg_ready write capacity_limit (reset 64); cfg_ready
// is always high. Writes are to be made only while idle; the block does not enforce it.
//
// Reset (rst_n low, synchronous) empties the list and restores the limit.
// Entry contents are not cleared; entries past the length are never read.
`timescale 1ns / 1ps
`default_nettype none
module array_list_engine_top #(
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [3:0]                in_func,
  input  wire logic [5:0]                in_position,
  input  wire logic signed [31:0]        in_operand_value,
  output logic                           out_valid,
  output logic signed [ale_pkg::ResW-1:0] out_result_value,
  output logic [5:0]                     out_result_index,
  output logic [1:0]                     out_status,
  output logic [6:0]                     out_count_now,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [6:0]                cfg_capacity_limit
);
  import ale_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;  // address driven, waiting for data
  localparam logic [3:0] S_USE   = 4'd2;  // data valid, act on it
  localparam logic [3:0] S_RD2   = 4'd3;  // second read of a pair
  localparam logic [3:0] S_USE2  = 4'd4;
  localparam logic [3:0] S_WR2   = 4'd5;  // second write of a swap
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_FINAL = 4'd7;  // final single write then done

  logic [3:0]      state_r, state_nxt;
  logic [3:0]      op_r;
  logic [5:0]      pos_r;
  logic [31:0]     val_r;
  logic [LW-1:0]   len_r, len_nxt;
  logic [6:0]      cap_r;
  logic [LW:0]     i_r, i_nxt, j_r, j_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LW:0]     pass_r, pass_nxt;
  logic [31:0]     a_r, a_nxt;         // first datum of a pair
  logic signed [ResW-1:0] acc_r, acc_nxt;
  logic [IdxW-1:0] ridx_r, ridx_nxt;
  logic [1:0]      st_r, st_nxt;
  logic            swapped_unused;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wdata, rdata;
  logic [AW-1:0]   raddr_r, raddr_nxt;

  ale_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign raddr = raddr_r;
  assign swapped_unused = 1'b0;

  function automatic logic [AW-1:0] ad(input logic [LW:0] x);
    return x[AW-1:0];
  endfunction

  logic [LW:0] cap_eff, len_w;
  logic        full;
  assign cap_eff = ((LW+1)'(cap_r) < (LW+1)'(DEPTH)) ? (LW+1)'(cap_r) : (LW+1)'(DEPTH);
  assign len_w   = (LW+1)'(len_r);
  assign full    = len_w >= cap_eff;

  logic signed [ResW-1:0] rd_s;
  assign rd_s = ResW'(signed'(rdata));
  logic [LW:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; i_nxt = i_r; j_nxt = j_r; lo_nxt = lo_r; hi_nxt = hi_r;
    pass_nxt = pass_r; a_nxt = a_r; acc_nxt = acc_r; ridx_nxt = ridx_r;
    st_nxt = st_r; raddr_nxt = raddr_r;
    we = 1'b0; waddr = '0; wdata = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          acc_nxt = '0; ridx_nxt = '0; st_nxt = ST_OK;
          i_nxt = '0; j_nxt = '0; pass_nxt = '0;
          state_nxt = S_DONE;
          unique case (in_func)
            OP_APPEND: begin
              if (full) st_nxt = ST_FULL;
              else begin
                we = 1'b1; waddr = ad(len_w); wdata = in_operand_value;
                len_nxt = len_r + 1'b1;
              end
            end
            OP_INSERT, OP_SORTINS: begin
              if (full) st_nxt = ST_FULL;
              else if (in_func == OP_INSERT && (LW+1)'(in_position) > len_w)
                st_nxt = ST_RANGE;
              else if (len_w == 0) begin
                we = 1'b1; waddr = '0; wdata = in_operand_value;
                len_nxt = len_r + 1'b1;
              end else if (in_func == OP_INSERT && (LW+1)'(in_position) == len_w) begin
                we = 1'b1; waddr = ad(len_w); wdata = in_operand_value;
                len_nxt = len_r + 1'b1;
              end else begin
                i_nxt = len_w; raddr_nxt = ad(len_w - 1'b1); state_nxt = S_RD;
              end
            end
            OP_DELETE: begin
              if ((LW+1)'(in_position) >= len_w) begin
                acc_nxt = '1; st_nxt = ST_RANGE;
              end else begin
                i_nxt = (LW+1)'(in_position); raddr_nxt = ad((LW+1)'(in_position));
                state_nxt = S_RD;
              end
            end
            OP_FIND: begin
              st_nxt = ST_NOTFND;
              if (len_w != 0) begin raddr_nxt = '0; state_nxt = S_RD; end
            end
            OP_BSEARCH: begin
              st_nxt = ST_NOTFND; lo_nxt = '0; hi_nxt = len_w;
              if (len_w != 0) begin
                raddr_nxt = ad(len_w >> 1); state_nxt = S_RD;
              end
            end
            OP_SORT: begin
              if (len_w > 1) begin raddr_nxt = '0; state_nxt = S_RD; end
            end
            OP_MAX: begin
              if (len_w == 0) st_nxt = ST_NOTFND;
              else begin raddr_nxt = '0; state_nxt = S_RD; end
            end
            OP_SUM: begin
              if (len_w != 0) begin raddr_nxt = '0; state_nxt = S_RD; end
            end
            OP_REVERSE: begin
              if (len_w > 1) begin
                j_nxt = len_w - 1'b1; raddr_nxt = '0; state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_USE;
      S_USE: begin
        state_nxt = S_RD;
        unique case (op_r)
          OP_INSERT, OP_SORTINS: begin
            // rdata = entry[i-1]; shift it up while the gap must move down
            if ((op_r == OP_INSERT && i_r > (LW+1)'(pos_r)) ||
                (op_r == OP_SORTINS && (rdata ^ 32'h8000_0000) > (val_r ^ 32'h8000_0000))) begin
              we = 1'b1; waddr = ad(i_r); wdata = rdata;
              i_nxt = i_r - 1'b1;
              if (i_r == 1 || (op_r == OP_INSERT && i_r - 1'b1 == (LW+1)'(pos_r)))
                state_nxt = S_FINAL;
              else raddr_nxt = ad(i_r - 2'd2);
            end else begin
              state_nxt = S_FINAL;
            end
          end
          OP_DELETE: begin
            if (i_r == (LW+1)'(pos_r) && acc_r == 0 && st_r == ST_OK && pass_r == 0) begin
              acc_nxt = rd_s; pass_nxt = (LW+1)'(1);
            end else begin
              we = 1'b1; waddr = ad(i_r - 1'b1); wdata = rdata;
            end
            if (i_r + 1'b1 >= len_w) begin
              len_nxt = len_r - 1'b1; state_nxt = S_DONE;
            end else begin
              i_nxt = i_r + 1'b1; raddr_nxt = ad(i_r + 1'b1);
            end
          end
          OP_FIND: begin
            if (rdata == val_r) begin
              ridx_nxt = IdxW'(i_r); st_nxt = ST_OK;
              if (i_r == 0) state_nxt = S_DONE;
              else begin
                a_nxt = rdata; raddr_nxt = '0; state_nxt = S_RD2;
              end
            end else if (i_r + 1'b1 >= len_w) state_nxt = S_DONE;
            else begin i_nxt = i_r + 1'b1; raddr_nxt = ad(i_r + 1'b1); end
          end
          OP_BSEARCH: begin
            if (rdata == val_r) begin
              ridx_nxt = IdxW'(mid); st_nxt = ST_OK; state_nxt = S_DONE;
            end else begin
              if ((val_r ^ 32'h8000_0000) < (rdata ^ 32'h8000_0000)) begin
                hi_nxt = mid;
              end else begin
                lo_nxt = mid + 1'b1;
              end
              if (((val_r ^ 32'h8000_0000) < (rdata ^ 32'h8000_0000)) ?
                  (lo_r >= mid) : (mid + 1'b1 >= hi_r))
                state_nxt = S_DONE;
              else if ((val_r ^ 32'h8000_0000) < (rdata ^ 32'h8000_0000))
                raddr_nxt = ad(lo_r + ((mid - lo_r) >> 1));
              else
                raddr_nxt = ad(mid + 1'b1 + ((hi_r - mid - 1'b1) >> 1));
            end
          end
          OP_MAX, OP_SUM: begin
            if (op_r == OP_SUM) acc_nxt = acc_r + rd_s;
            else if (i_r == 0 || rd_s > acc_r) acc_nxt = rd_s;
            if (i_r + 1'b1 >= len_w) state_nxt = S_DONE;
            else begin i_nxt = i_r + 1'b1; raddr_nxt = ad(i_r + 1'b1); end
          end
          OP_SORT, OP_REVERSE: begin
            a_nxt = rdata;
            raddr_nxt = (op_r == OP_SORT) ? ad(j_r + 1'b1) : ad(j_r);
            state_nxt = S_RD2;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RD2: state_nxt = S_USE2;
      S_USE2: begin
        // a_r = first entry, rdata = second entry of the pair
        unique case (op_r)
          OP_FIND: begin
            we = 1'b1; waddr = '0; wdata = a_r;
            a_nxt = rdata; state_nxt = S_WR2;
          end
          OP_REVERSE: begin
            we = 1'b1; waddr = ad(i_r); wdata = rdata; state_nxt = S_WR2;
          end
          OP_SORT: begin
            if ((a_r ^ 32'h8000_0000) > (rdata ^ 32'h8000_0000)) begin
              we = 1'b1; waddr = ad(j_r); wdata = rdata; state_nxt = S_WR2;
            end else begin
              state_nxt = S_WR2;
              a_nxt = rdata; // no swap: rewrite harmlessly
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_WR2: begin
        unique case (op_r)
          OP_FIND: begin
            we = 1'b1; waddr = ad(i_r); wdata = a_r; state_nxt = S_DONE;
          end
          OP_REVERSE: begin
            we = 1'b1; waddr = ad(j_r); wdata = a_r;
            if (i_r + 1'b1 >= j_r - 1'b1) state_nxt = S_DONE;
            else begin
              i_nxt = i_r + 1'b1; j_nxt = j_r - 1'b1;
              raddr_nxt = ad(i_r + 1'b1); state_nxt = S_RD;
            end
          end
          OP_SORT: begin
            we = 1'b1; waddr = ad(j_r + 1'b1); wdata = a_r;
            if (j_r + 2'd2 >= len_w - pass_r) begin
              if (pass_r + 2'd2 >= len_w) state_nxt = S_DONE;
              else begin
                pass_nxt = pass_r + 1'b1; j_nxt = '0; raddr_nxt = '0; state_nxt = S_RD;
              end
            end else begin
              j_nxt = j_r + 1'b1; raddr_nxt = ad(j_r + 1'b1); state_nxt = S_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FINAL: begin
        we = 1'b1; waddr = ad(i_r); wdata = val_r;
        len_nxt = len_r + 1'b1;
        if (op_r == OP_SORTINS) ridx_nxt = IdxW'(i_r);
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // In the sort no-swap path a_r takes the second entry so the rewrite of
  // j+1 stores the value it already held; the j slot is left untouched.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cap_r   <= 7'd64;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_capacity_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r <= in_func; pos_r <= in_position; val_r <= in_operand_value;
    end
    i_r <= i_nxt; j_r <= j_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    pass_r <= pass_nxt; a_r <= a_nxt; acc_r <= acc_nxt;
    ridx_r <= ridx_nxt; st_r <= st_nxt; raddr_r <= raddr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= (state_r == S_DONE) && !swapped_unused;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_result_value <= acc_r;
      out_result_index <= ridx_r;
      out_status       <= st_r;
      out_count_now    <= 7'(len_r);
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (LW+1)'(len_r) <= (LW+1)'(DEPTH)) else $error("length beyond depth");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> state_r == S_IDLE) else $error("done not followed by idle");
endmodule
`default_nettype wire
